// File: src/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;
  localparam int QUEUE_DEPTH   = 4;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT  = 4'd15
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              is_div;
    logic              div_zero;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } item_t;

endpackage

// File: src/fixed_point_alu.sv
// Top level of the signed 32-bit fixed-point ALU.
// Throughput: one operation per cycle while the output is not stalled;
// the divider resolves one quotient bit per stage.
// A four-entry queue decouples input from the pipeline, which stalls only on output.
// Reset (rst_n low, synchronous) empties the queue and clears all stage valids.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_op,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_compare_true,
  output logic                     out_divide_by_zero
);

  item_t push_item, head_item;
  logic  push, pop, full, not_empty;

  fpa_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .q_full       (full),
    .q_push       (push),
    .q_item       (push_item)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (not_empty),
    .q_item             (head_item),
    .q_pop              (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_value   (out_result_value),
    .out_compare_true   (out_compare_true),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

// File: src/fpa_front.sv
// Front end: accepts operations and classifies them for the queue.
module fpa_front import fpa_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [3:0]               in_op,
  input  logic signed [DATA_W-1:0] in_operand_a,
  input  logic signed [DATA_W-1:0] in_operand_b,
  input  logic                     q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.op       = op_t'(in_op);
    q_item.is_div   = (op_t'(in_op) == OP_DIV);
    q_item.div_zero = (in_operand_b == '0);
    q_item.a        = in_operand_a;
    q_item.b        = in_operand_b;
  end

endmodule

// File: src/fpa_queue.sv
// Short queue between the front end and the execution pipeline.
module fpa_queue import fpa_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head_item
);

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  head_r, tail_r;
  logic [CW-1:0]  cnt_r;
  logic           do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[head_r];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[tail_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
      end
      if (do_pop) begin
        head_r <= (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/fpa_back.sv
// Execution pipeline: simple ops, multiplier and one-bit-per-stage divider.
module fpa_back import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic                     out_compare_true,
  output logic                     out_divide_by_zero
);

  localparam int DW = DATA_W + FRAC_BITS;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              is_div;
    logic              dz;
    logic              cmp;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] rem;
    logic [DW-1:0]     dq;
  } stage_t;

  stage_t                     st_r [DW+1];
  stage_t                     st_nxt [DW+1];
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic                       adv;

  logic                       out_valid_r;
  logic [DATA_W-1:0]          out_res_r;
  logic                       out_cmp_r, out_dz_r;

  logic signed [DATA_W-1:0]   a_s, b_s;
  logic [DATA_W-1:0]          ma, bias;
  logic [DATA_W-1:0]          q32, fin;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  assign a_s     = $signed(q_item.a);
  assign b_s     = $signed(q_item.b);
  assign prod_sh = prod_r >>> FRAC_BITS;
  assign bias    = q_item.a[DATA_W-1] ? DATA_W'((64'd1 << FRAC_BITS) - 64'd1) : '0;
  assign ma      = q_item.a[DATA_W-1] ? DATA_W'(0) - q_item.a : q_item.a;

  always_comb begin
    st_nxt[0]        = '0;
    st_nxt[0].valid  = q_valid;
    st_nxt[0].op     = q_item.op;
    st_nxt[0].is_div = q_item.is_div;
    st_nxt[0].dz     = q_item.is_div && q_item.div_zero;
    st_nxt[0].neg    = q_item.a[DATA_W-1] ^ q_item.b[DATA_W-1];
    st_nxt[0].mb     = q_item.b[DATA_W-1] ? DATA_W'(0) - q_item.b : q_item.b;
    st_nxt[0].rem    = '0;
    st_nxt[0].dq     = DW'(ma) << FRAC_BITS;
    case (q_item.op)
      OP_ADD:      st_nxt[0].res = q_item.a + q_item.b;
      OP_SUB:      st_nxt[0].res = q_item.a - q_item.b;
      OP_GT:       st_nxt[0].cmp = (a_s > b_s);
      OP_LT:       st_nxt[0].cmp = (a_s < b_s);
      OP_GE:       st_nxt[0].cmp = (a_s >= b_s);
      OP_LE:       st_nxt[0].cmp = (a_s <= b_s);
      OP_EQ:       st_nxt[0].cmp = (q_item.a == q_item.b);
      OP_NE:       st_nxt[0].cmp = (q_item.a != q_item.b);
      OP_MIN:      st_nxt[0].res = (a_s < b_s) ? q_item.a : q_item.b;
      OP_MAX:      st_nxt[0].res = (a_s > b_s) ? q_item.a : q_item.b;
      OP_INC:      st_nxt[0].res = q_item.a + 1'b1;
      OP_DEC:      st_nxt[0].res = q_item.a - 1'b1;
      OP_FROM_INT: st_nxt[0].res = q_item.a << FRAC_BITS;
      OP_TO_INT:   st_nxt[0].res = DATA_W'($signed(q_item.a + bias) >>> FRAC_BITS);
      default:     st_nxt[0].res = '0;
    endcase
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [DATA_W:0] rem2;
    logic            ge;
    logic [DATA_W:0] diff;

    assign rem2 = {st_r[k].rem, st_r[k].dq[DW-1]};
    assign ge   = (rem2 >= {1'b0, st_r[k].mb});
    assign diff = rem2 - {1'b0, st_r[k].mb};

    always_comb begin
      st_nxt[k+1]     = st_r[k];
      st_nxt[k+1].rem = ge ? diff[DATA_W-1:0] : rem2[DATA_W-1:0];
      st_nxt[k+1].dq  = {st_r[k].dq[DW-2:0], ge};
      if (k == 0 && st_r[k].op == OP_MUL) begin
        st_nxt[k+1].res = prod_sh[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= a_s * b_s;
    end
  end

  for (genvar k = 0; k <= DW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].valid <= 1'b0;
      end else if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign q32 = st_r[DW].dq[DATA_W-1:0];

  always_comb begin
    fin = st_r[DW].res;
    if (st_r[DW].is_div) begin
      if (st_r[DW].dz) begin
        fin = '0;
      end else begin
        fin = st_r[DW].neg ? DATA_W'(0) - q32 : q32;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_r[DW].valid;
      out_res_r   <= fin;
      out_cmp_r   <= st_r[DW].cmp;
      out_dz_r    <= st_r[DW].dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = $signed(out_res_r);
  assign out_compare_true   = out_cmp_r;
  assign out_divide_by_zero = out_dz_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_res_r == '0)
    else $error("divide by zero result not zero");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_cmp_r && out_dz_r))
    else $error("compare and divide-by-zero both set");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(out_res_r) && out_valid_r)
    else $error("stalled result changed");

endmodule
